[hw/rtl/mm3_pkg.sv]
// Shared types, constants and field widths for the MurmurHash3 x86_32 stream core.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package mm3_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 3;

    localparam logic [WORD_W-1:0]  MIX_C1  = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0]  MIX_C2  = 32'h1b873593;
    localparam logic [WORD_W-1:0]  MIX_ADD = 32'he6546b64;
    localparam logic [WORD_W-1:0]  FIN_M1  = 32'h85ebca6b;
    localparam logic [WORD_W-1:0]  FIN_M2  = 32'hc2b2ae35;
    localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

    // Queue between the key-mix front and the hash back.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration port: a single 32-bit register, the seed, at word address 0.
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_SEED = 1'b0;

    typedef enum logic [1:0] {
        WK_EMPTY,
        WK_TAIL,
        WK_FULL
    } t_word_kind;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FIN1,
        ST_FIN2,
        ST_EMIT
    } t_back_state;

    typedef struct packed {
        logic [WORD_W-1:0]  key;
        logic [COUNT_W-1:0] count;
        t_word_kind         kind;
        logic               last;
    } t_mix_item;

endpackage

[hw/rtl/mm3_if.sv]
// Valid/ready channel interfaces for message words in and hash results out.
// Depends on mm3_pkg for field widths.
interface mm3_in_if;
    logic                            valid;
    logic                            ready;
    logic [mm3_pkg::WORD_W-1:0]      data_word;
    logic [mm3_pkg::COUNT_W-1:0]     valid_bytes;
    logic                            last;

    modport source (output valid, output data_word, output valid_bytes, output last,
                    input ready);
    modport sink   (input valid, input data_word, input valid_bytes, input last,
                    output ready);
endinterface

interface mm3_out_if;
    logic                       valid;
    logic                       ready;
    logic [mm3_pkg::WORD_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

[hw/rtl/mm3_front.sv]
// Front end: accepts message words, masks the tail bytes, classifies the word
// and runs the two-multiply key mix in a stalling two-stage pipeline. Uses mm3_pkg, mm3_if.
module mm3_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mm3_in_if.sink               i_msg,
    output mm3_pkg::t_mix_item   o_item,
    output logic                 o_item_valid,
    input  logic                 i_item_ready
);

    logic                          advance;
    logic [mm3_pkg::COUNT_W-1:0]   count_sat;
    logic [mm3_pkg::WORD_W-1:0]    masked;
    mm3_pkg::t_word_kind           kind;
    logic [mm3_pkg::WORD_W-1:0]    s1_rot;

    logic                          r_s1_valid;
    logic [mm3_pkg::WORD_W-1:0]    r_s1_prod;
    logic [mm3_pkg::COUNT_W-1:0]   r_s1_count;
    mm3_pkg::t_word_kind           r_s1_kind;
    logic                          r_s1_last;
    logic                          r_s2_valid;
    mm3_pkg::t_mix_item            r_s2_item;

    function automatic logic [mm3_pkg::COUNT_W-1:0] COUNT_W_EXT(input int unsigned v);
        return v[mm3_pkg::COUNT_W-1:0];
    endfunction

    // The whole pipeline moves together whenever its last stage can drain.
    assign advance     = !r_s2_valid || i_item_ready;
    assign i_msg.ready = advance;

    always_comb begin
        count_sat = (i_msg.valid_bytes > mm3_pkg::FULL_COUNT) ? mm3_pkg::FULL_COUNT
                                                              : i_msg.valid_bytes;
        for (int b = 0; b < 4; b++) begin
            masked[8*b +: 8] = (COUNT_W_EXT(b) < count_sat) ? i_msg.data_word[8*b +: 8]
                                                           : 8'h00;
        end
        if (count_sat == mm3_pkg::FULL_COUNT) begin
            kind = mm3_pkg::WK_FULL;
        end else if (count_sat == '0) begin
            kind = mm3_pkg::WK_EMPTY;
        end else begin
            kind = mm3_pkg::WK_TAIL;
        end
        s1_rot = {r_s1_prod[16:0], r_s1_prod[31:17]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_msg.valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_prod        <= masked * mm3_pkg::MIX_C1;
            r_s1_count       <= count_sat;
            r_s1_kind        <= kind;
            r_s1_last        <= i_msg.last;
            r_s2_item.key    <= s1_rot * mm3_pkg::MIX_C2;
            r_s2_item.count  <= r_s1_count;
            r_s2_item.kind   <= r_s1_kind;
            r_s2_item.last   <= r_s1_last;
        end
    end

    assign o_item       = r_s2_item;
    assign o_item_valid = r_s2_valid;

endmodule

[hw/rtl/mm3_fifo.sv]
// Short queue of key-mixed items between the front end and the hash back end.
// Uses mm3_pkg for the item type and depth.
module mm3_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    input  mm3_pkg::t_mix_item   i_push_item,
    output logic                 o_push_ready,
    output logic                 o_pop_valid,
    output mm3_pkg::t_mix_item   o_pop_item,
    input  logic                 i_pop_ready
);

    mm3_pkg::t_mix_item               r_mem [mm3_pkg::FIFO_DEPTH];
    logic [mm3_pkg::FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [mm3_pkg::FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [mm3_pkg::FIFO_CNT_W-1:0]   r_count;
    logic                             push;
    logic                             pop;

    assign o_push_ready = (r_count != mm3_pkg::FIFO_CNT_W'(mm3_pkg::FIFO_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == mm3_pkg::FIFO_PTR_W'(mm3_pkg::FIFO_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == mm3_pkg::FIFO_PTR_W'(mm3_pkg::FIFO_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

[hw/rtl/mm3_back.sv]
// Back end: folds key-mixed items into the running hash and byte total, then runs
// the final avalanche and holds the result in an output register. Uses mm3_pkg, mm3_if.
module mm3_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [mm3_pkg::WORD_W-1:0]   i_seed,
    input  mm3_pkg::t_mix_item           i_item,
    input  logic                         i_item_valid,
    output logic                         o_item_ready,
    mm3_out_if.source                    o_hash
);

    mm3_pkg::t_back_state           r_state, n_state;
    logic                           r_start, n_start;
    logic [mm3_pkg::WORD_W-1:0]     r_hash, n_hash;
    logic [mm3_pkg::WORD_W-1:0]     r_total, n_total;
    logic [mm3_pkg::WORD_W-1:0]     r_fin, n_fin;
    logic                           r_out_valid, n_out_valid;
    logic [mm3_pkg::WORD_W-1:0]     r_out, n_out;

    logic [mm3_pkg::WORD_W-1:0]     base_hash;
    logic [mm3_pkg::WORD_W-1:0]     base_total;
    logic [mm3_pkg::WORD_W-1:0]     mixed;
    logic [mm3_pkg::WORD_W-1:0]     rot;
    logic [mm3_pkg::WORD_W-1:0]     upd;
    logic [mm3_pkg::WORD_W-1:0]     fold;

    always_comb begin
        base_hash  = r_start ? i_seed : r_hash;
        base_total = r_start ? '0 : r_total;
        mixed      = base_hash ^ i_item.key;
        rot        = {mixed[18:0], mixed[31:19]};
        case (i_item.kind)
            mm3_pkg::WK_FULL: upd = {rot[29:0], 2'b00} + rot + mm3_pkg::MIX_ADD;
            mm3_pkg::WK_TAIL: upd = mixed;
            default:          upd = base_hash;
        endcase
        fold = r_hash ^ r_total;
    end

    always_comb begin
        n_state      = r_state;
        n_start      = r_start;
        n_hash       = r_hash;
        n_total      = r_total;
        n_fin        = r_fin;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_hash.ready;
        o_item_ready = 1'b0;
        case (r_state)
            mm3_pkg::ST_RUN: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_hash  = upd;
                    n_total = base_total + {{(mm3_pkg::WORD_W - mm3_pkg::COUNT_W){1'b0}},
                                            i_item.count};
                    n_start = i_item.last;
                    if (i_item.last) begin
                        n_state = mm3_pkg::ST_FIN1;
                    end
                end
            end
            mm3_pkg::ST_FIN1: begin
                n_fin   = (fold ^ (fold >> 16)) * mm3_pkg::FIN_M1;
                n_state = mm3_pkg::ST_FIN2;
            end
            mm3_pkg::ST_FIN2: begin
                n_fin   = (r_fin ^ (r_fin >> 13)) * mm3_pkg::FIN_M2;
                n_state = mm3_pkg::ST_EMIT;
            end
            mm3_pkg::ST_EMIT: begin
                // Wait here only while the previous result has not been taken.
                if (!r_out_valid || o_hash.ready) begin
                    n_out       = r_fin ^ (r_fin >> 16);
                    n_out_valid = 1'b1;
                    n_state     = mm3_pkg::ST_RUN;
                end
            end
            default: n_state = mm3_pkg::ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mm3_pkg::ST_RUN;
            r_start     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash  <= n_hash;
        r_total <= n_total;
        r_fin   <= n_fin;
        r_out   <= n_out;
    end

    assign o_hash.valid      = r_out_valid;
    assign o_hash.hash_value = r_out;

endmodule

[hw/rtl/murmur3_32_stream_hash_core.sv]
// MurmurHash3 x86_32 stream core: message words enter on i_msg, one finished hash per
// message leaves on o_hash, and the seed sits in an APB register at byte address 0.
// The back end folds one word per cycle, so words stream at one per cycle through the
// key-mix pipeline and a four-entry queue except while the back end finishes a message:
// after its last word come two avalanche multiplies and the load of the output register.
// A finished hash waits in the output register while the next message is folded, though
// that message's own result waits until it is taken. The seed is read when a message's
// first word reaches the back end, so write it only while the core is idle.
module murmur3_32_stream_hash_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mm3_in_if.sink                            i_msg,
    mm3_out_if.source                         o_hash,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mm3_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mm3_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mm3_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [mm3_pkg::WORD_W-1:0]  r_seed;
    logic                        seed_sel;

    mm3_pkg::t_mix_item          front_item;
    logic                        front_valid;
    logic                        front_ready;
    mm3_pkg::t_mix_item          back_item;
    logic                        back_valid;
    logic                        back_ready;

    assign pready   = 1'b1;
    assign seed_sel = (paddr[mm3_pkg::APB_ADDR_W-1:2] == mm3_pkg::REG_SEED);
    assign prdata   = seed_sel ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && pready && seed_sel) begin
            r_seed <= pwdata;
        end
    end

    mm3_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_msg        (i_msg),
        .o_item       (front_item),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready)
    );

    mm3_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_item  (front_item),
        .o_push_ready (front_ready),
        .o_pop_valid  (back_valid),
        .o_pop_item   (back_item),
        .i_pop_ready  (back_ready)
    );

    mm3_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_seed),
        .i_item       (back_item),
        .i_item_valid (back_valid),
        .o_item_ready (back_ready),
        .o_hash       (o_hash)
    );

endmodule
